>>> hw/rtl/sog_pkg.sv
// sog_pkg: shared types and constants for the shifter operand generator
// holds the transfer structs, the decoded control struct and the mask codes
// no dependencies
`default_nettype none

package sog_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned AmtW  = 5;

  localparam logic [WordW-1:0] AllOnes = '1;

  // shift type codes, instruction bits 6:5
  localparam logic [1:0] SHIFT_LSL = 2'd0;
  localparam logic [1:0] SHIFT_LSR = 2'd1;
  localparam logic [1:0] SHIFT_ASR = 2'd2;
  localparam logic [1:0] SHIFT_ROR = 2'd3;

  // instruction bit positions
  localparam int unsigned BitImm    = 25;
  localparam int unsigned BitRegSh  = 4;

  // which bits of the rotated word are replaced by the fill bit
  typedef enum logic [1:0] {
    MASK_NONE,
    MASK_HI,
    MASK_LO,
    MASK_ALL
  } mask_kind_t;

  typedef struct packed {
    logic [WordW-1:0] instr;
    logic [WordW-1:0] rm_value;
    logic [WordW-1:0] rs_value;
    logic             carry_in;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] operand_out;
    logic             carry_out;
  } out_t;

  // decoded form of one instruction, held in the first pipeline stage
  typedef struct packed {
    logic [WordW-1:0] src;
    logic [AmtW-1:0]  ramt;
    mask_kind_t       mask_kind;
    logic [AmtW-1:0]  mask_n;
    logic             fill;
    logic             carry;
  } ctrl_t;

endpackage : sog_pkg

`default_nettype wire

>>> hw/rtl/shifter_operand_generator.sv
// shifter_operand_generator: data-processing second operand and shifter carry
// three-stage pipeline: decode, coarse rotate with mask build, fine rotate with fill
// depends on sog_pkg and sog_decode
//
//   channel   signals          transfer
//   -------   --------------   ------------------------------------------
//   command   start, busy,     taken at a rising edge with start high and
//             item             busy low
//   result    done, result     shown for one cycle while done is high
//
// path: from the command transfer to the result strobe through the decode register,
//   coarse rotate register and output register
// rate: one command per cycle, busy is always low
// reset: rst, synchronous, clears the stage valid bits only
// stalls: none, the receiver takes every result in the cycle it is shown
`default_nettype none

module shifter_operand_generator
  import sog_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  item,
  output logic      done,
  output out_t      result
);

  // stage 1: decoded control
  ctrl_t dec;
  ctrl_t s1;
  logic  v1;

  // stage 2: coarse rotated word and fill mask
  logic [WordW-1:0] s2_word;
  logic [WordW-1:0] s2_mask;
  logic [1:0]       s2_fine;
  mask_kind_t       s2_kind;
  logic             s2_fill;
  logic             s2_carry;
  logic             v2;

  logic [WordW-1:0]   coarse_next;
  logic [WordW-1:0]   mask_next;
  logic [2*WordW-1:0] coarse_dbl;
  logic [2*WordW-1:0] fine_dbl;
  logic [WordW-1:0]   fine_word;
  out_t               result_next;

  // never holds a command off
  assign busy = 1'b0;

  sog_decode u_decode (
    .item (item),
    .ctrl (dec)
  );

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    s1 <= dec;
  end

  // rotate right by the upper three amount bits, in steps of four
  assign coarse_dbl  = {s1.src, s1.src} >> {s1.ramt[AmtW-1:2], 2'b00};
  assign coarse_next = coarse_dbl[WordW-1:0];

  // bits to be replaced by the fill value
  always_comb begin
    case (s1.mask_kind)
      MASK_NONE: mask_next = '0;
      MASK_HI:   mask_next = ~(AllOnes >> s1.mask_n);
      MASK_LO:   mask_next = ~(AllOnes << s1.mask_n);
      MASK_ALL:  mask_next = AllOnes;
      default:   mask_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    s2_word  <= coarse_next;
    s2_mask  <= mask_next;
    s2_fine  <= s1.ramt[1:0];
    s2_kind  <= s1.mask_kind;
    s2_fill  <= s1.fill;
    s2_carry <= s1.carry;
  end

  // finish the rotation by zero to three places, then apply the fill
  assign fine_dbl  = {s2_word, s2_word} >> s2_fine;
  assign fine_word = fine_dbl[WordW-1:0];

  always_comb begin
    result_next.operand_out = (fine_word & ~s2_mask) | ({WordW{s2_fill}} & s2_mask);
    result_next.carry_out   = s2_carry;
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // a strobe only ever follows an earlier command transfer
  a_done_follows_start : assert property (
    @(posedge clk) disable iff (rst) done |-> $past(start, 3)
  ) else $error("result strobe without a command transfer");

  // a full-width fill gives a word of the fill bit alone
  a_fill_all : assert property (
    @(posedge clk) disable iff (rst)
      (v2 && s2_kind == MASK_ALL) |=> (result.operand_out == {WordW{$past(s2_fill)}})
  ) else $error("full fill did not cover the operand");

  // carry is settled at decode and carried unchanged to the output
  a_carry_path : assert property (
    @(posedge clk) disable iff (rst) v1 |=> ##1 (result.carry_out == $past(s1.carry, 2))
  ) else $error("carry changed on its way through the pipeline");

  // no mask and no rotation passes the source word straight through
  a_pass_through : assert property (
    @(posedge clk) disable iff (rst)
      (v1 && s1.mask_kind == MASK_NONE && s1.ramt == '0) |=> ##1
        (result.operand_out == $past(s1.src, 2))
  ) else $error("unshifted operand was altered");

endmodule : shifter_operand_generator

`default_nettype wire

>>> hw/rtl/sog_decode.sv
// sog_decode: combinational decode of the eleven shifter operand forms
// turns each form into a right rotation, a fill mask and a resolved carry
// depends on sog_pkg
`default_nettype none

module sog_decode
  import sog_pkg::*;
(
  input  wire in_t item,
  output ctrl_t    ctrl
);

  logic [WordW-1:0] rm;
  logic [7:0]       s;
  logic [AmtW-1:0]  n;
  logic [AmtW-1:0]  neg_n;
  logic [AmtW-1:0]  neg_s;
  logic [AmtW-1:0]  rot;
  logic [AmtW-1:0]  n_m1;
  logic [AmtW-1:0]  s_m1;
  logic [AmtW-1:0]  rot_m1;
  logic [WordW-1:0] imm_ext;
  logic             c;
  logic             sign;

  assign rm      = item.rm_value;
  assign s       = item.rs_value[7:0];
  assign n       = item.instr[11:7];
  assign neg_n   = AmtW'(0) - n;
  assign neg_s   = AmtW'(0) - s[AmtW-1:0];
  assign rot     = {item.instr[11:8], 1'b0};
  assign n_m1    = n - AmtW'(1);
  assign s_m1    = s[AmtW-1:0] - AmtW'(1);
  assign rot_m1  = rot - AmtW'(1);
  assign imm_ext = {{(WordW-8){1'b0}}, item.instr[7:0]};
  assign c       = item.carry_in;
  assign sign    = rm[WordW-1];

  always_comb begin
    ctrl.src       = rm;
    ctrl.ramt      = '0;
    ctrl.mask_kind = MASK_NONE;
    ctrl.mask_n    = '0;
    ctrl.fill      = 1'b0;
    ctrl.carry     = c;
    if (item.instr[BitImm]) begin
      // rotated 8-bit immediate
      ctrl.src   = imm_ext;
      ctrl.ramt  = rot;
      ctrl.carry = (rot == '0) ? c : imm_ext[rot_m1];
    end else if (!item.instr[BitRegSh]) begin
      // shift by immediate amount
      case (item.instr[6:5])
        SHIFT_LSL: begin
          if (n != '0) begin
            ctrl.ramt      = neg_n;
            ctrl.mask_kind = MASK_LO;
            ctrl.mask_n    = n;
            ctrl.carry     = rm[neg_n];
          end
        end
        SHIFT_LSR: begin
          if (n == '0) begin
            ctrl.mask_kind = MASK_ALL;
            ctrl.carry     = sign;
          end else begin
            ctrl.ramt      = n;
            ctrl.mask_kind = MASK_HI;
            ctrl.mask_n    = n;
            ctrl.carry     = rm[n_m1];
          end
        end
        SHIFT_ASR: begin
          ctrl.fill = sign;
          if (n == '0) begin
            ctrl.mask_kind = MASK_ALL;
            ctrl.carry     = sign;
          end else begin
            ctrl.ramt      = n;
            ctrl.mask_kind = MASK_HI;
            ctrl.mask_n    = n;
            ctrl.carry     = rm[n_m1];
          end
        end
        default: begin
          if (n == '0) begin
            // rrx
            ctrl.src   = {c, rm[WordW-1:1]};
            ctrl.carry = rm[0];
          end else begin
            ctrl.ramt  = n;
            ctrl.carry = rm[n_m1];
          end
        end
      endcase
    end else if (s != '0) begin
      // shift by register amount
      case (item.instr[6:5])
        SHIFT_LSL: begin
          if (s < 8'(WordW)) begin
            ctrl.ramt      = neg_s;
            ctrl.mask_kind = MASK_LO;
            ctrl.mask_n    = s[AmtW-1:0];
            ctrl.carry     = rm[neg_s];
          end else begin
            ctrl.mask_kind = MASK_ALL;
            ctrl.carry     = (s == 8'(WordW)) ? rm[0] : 1'b0;
          end
        end
        SHIFT_LSR: begin
          if (s < 8'(WordW)) begin
            ctrl.ramt      = s[AmtW-1:0];
            ctrl.mask_kind = MASK_HI;
            ctrl.mask_n    = s[AmtW-1:0];
            ctrl.carry     = rm[s_m1];
          end else begin
            ctrl.mask_kind = MASK_ALL;
            ctrl.carry     = (s == 8'(WordW)) ? sign : 1'b0;
          end
        end
        SHIFT_ASR: begin
          ctrl.fill = sign;
          if (s < 8'(WordW)) begin
            ctrl.ramt      = s[AmtW-1:0];
            ctrl.mask_kind = MASK_HI;
            ctrl.mask_n    = s[AmtW-1:0];
            ctrl.carry     = rm[s_m1];
          end else begin
            ctrl.mask_kind = MASK_ALL;
            ctrl.carry     = sign;
          end
        end
        default: begin
          ctrl.ramt  = s[AmtW-1:0];
          ctrl.carry = (s[AmtW-1:0] == '0) ? sign : rm[s_m1];
        end
      endcase
    end
  end

endmodule : sog_decode

`default_nettype wire
